@@ hw/rtl/csf_pkg.sv @@
// Shared types and constants for the common slot finder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package csf_pkg;

  localparam int SLOT_CAP = 256;
  localparam int ADDR_W   = (SLOT_CAP > 1) ? $clog2(SLOT_CAP) : 1;
  localparam int CNT_W    = $clog2(SLOT_CAP + 1);

  localparam logic KIND_FIRST = 1'b0;

  typedef logic [63:0] slot_key_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] slot_start;
    logic [31:0] slot_end;
    logic        last;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [31:0] meet_start;
    logic [31:0] meet_end;
    logic        overflow;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_DONE
  } eng_state_t;

endpackage

@@ hw/rtl/csf_slot_mem.sv @@
// Slot store: one write port, one read port, registered read data.
// Depends on csf_pkg.
`timescale 1ns / 1ps

module csf_slot_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [csf_pkg::ADDR_W-1:0] wr_addr,
  input  csf_pkg::slot_key_t        wr_data,
  input  logic                      rd_en,
  input  logic [csf_pkg::ADDR_W-1:0] rd_addr,
  output csf_pkg::slot_key_t        rd_data
);
  import csf_pkg::*;

  slot_key_t mem [SLOT_CAP];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/csf_engine.sv @@
// Sorted insertion into the two slot stores and the two-pointer walk.
// Depends on csf_pkg and csf_slot_mem.
`timescale 1ns / 1ps

module csf_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  csf_pkg::in_word_t  in_word,
  input  logic [31:0]        min_dur,
  output logic               res_valid,
  input  logic               res_ready,
  output csf_pkg::out_word_t res_word
);
  import csf_pkg::*;

  eng_state_t state_r, state_nxt;
  logic       kind_r, kind_nxt;
  logic       last_r, last_nxt;
  slot_key_t  key_r, key_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic       drop_r, drop_nxt;
  out_word_t  res_r, res_nxt;

  logic              wr_en_a, wr_en_b, rd_en_a, rd_en_b;
  logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
  slot_key_t         wr_data, rd_a, rd_b, rd_cur;
  logic [CNT_W-1:0]  n_in, n_m1, pos_m1, pos_m2;
  logic [31:0]       as_v, ae_v, bs_v, be_v, lo_v, hi_v, span_v;
  logic              hit_v;

  csf_slot_mem u_mem_a (
    .clk(clk), .wr_en(wr_en_a), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en_a), .rd_addr(rd_addr_a), .rd_data(rd_a)
  );

  csf_slot_mem u_mem_b (
    .clk(clk), .wr_en(wr_en_b), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en_b), .rd_addr(rd_addr_b), .rd_data(rd_b)
  );

  assign n_in   = (in_word.kind == KIND_FIRST) ? cnt_a_r : cnt_b_r;
  assign n_m1   = n_in - CNT_W'(1);
  assign pos_m1 = pos_r - CNT_W'(1);
  assign pos_m2 = pos_r - CNT_W'(2);
  assign rd_cur = (kind_r == KIND_FIRST) ? rd_a : rd_b;

  assign as_v   = rd_a[63:32];
  assign ae_v   = rd_a[31:0];
  assign bs_v   = rd_b[63:32];
  assign be_v   = rd_b[31:0];
  assign lo_v   = (as_v > bs_v) ? as_v : bs_v;
  assign hi_v   = (ae_v < be_v) ? ae_v : be_v;
  assign span_v = hi_v - lo_v;
  assign hit_v  = (hi_v >= lo_v) && (span_v >= min_dur);

  assign in_stall  = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res_word  = res_r;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    last_nxt  = last_r;
    key_nxt   = key_r;
    pos_nxt   = pos_r;
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    drop_nxt  = drop_r;
    res_nxt   = res_r;
    wr_en_a   = 1'b0;
    wr_en_b   = 1'b0;
    wr_addr   = '0;
    wr_data   = key_r;
    rd_en_a   = 1'b0;
    rd_en_b   = 1'b0;
    rd_addr_a = '0;
    rd_addr_b = '0;

    unique case (state_r)
      ST_IDLE: begin
        i_nxt = '0;
        j_nxt = '0;
        if (in_valid) begin
          kind_nxt = in_word.kind;
          last_nxt = in_word.last;
          key_nxt  = {in_word.slot_start, in_word.slot_end};
          wr_data  = {in_word.slot_start, in_word.slot_end};
          if (n_in >= CNT_W'(SLOT_CAP)) begin
            drop_nxt  = 1'b1;
            state_nxt = in_word.last ? ST_WALK_RD : ST_IDLE;
          end else if (n_in == '0) begin
            wr_en_a = (in_word.kind == KIND_FIRST);
            wr_en_b = (in_word.kind != KIND_FIRST);
            if (in_word.kind == KIND_FIRST) cnt_a_nxt = cnt_a_r + CNT_W'(1);
            else                            cnt_b_nxt = cnt_b_r + CNT_W'(1);
            state_nxt = in_word.last ? ST_WALK_RD : ST_IDLE;
          end else begin
            rd_en_a   = (in_word.kind == KIND_FIRST);
            rd_en_b   = (in_word.kind != KIND_FIRST);
            rd_addr_a = n_m1[ADDR_W-1:0];
            rd_addr_b = n_m1[ADDR_W-1:0];
            pos_nxt   = n_in;
            state_nxt = ST_INS_CMP;
          end
        end
      end
      ST_INS_CMP: begin
        wr_en_a = (kind_r == KIND_FIRST);
        wr_en_b = (kind_r != KIND_FIRST);
        wr_addr = pos_r[ADDR_W-1:0];
        if (rd_cur > key_r) begin
          wr_data = rd_cur;
          pos_nxt = pos_m1;
          if (pos_m1 == '0) begin
            state_nxt = ST_INS_PUT;
          end else begin
            rd_en_a   = (kind_r == KIND_FIRST);
            rd_en_b   = (kind_r != KIND_FIRST);
            rd_addr_a = pos_m2[ADDR_W-1:0];
            rd_addr_b = pos_m2[ADDR_W-1:0];
          end
        end else begin
          if (kind_r == KIND_FIRST) cnt_a_nxt = cnt_a_r + CNT_W'(1);
          else                      cnt_b_nxt = cnt_b_r + CNT_W'(1);
          state_nxt = last_r ? ST_WALK_RD : ST_IDLE;
        end
      end
      ST_INS_PUT: begin
        wr_en_a = (kind_r == KIND_FIRST);
        wr_en_b = (kind_r != KIND_FIRST);
        wr_addr = pos_r[ADDR_W-1:0];
        if (kind_r == KIND_FIRST) cnt_a_nxt = cnt_a_r + CNT_W'(1);
        else                      cnt_b_nxt = cnt_b_r + CNT_W'(1);
        state_nxt = last_r ? ST_WALK_RD : ST_IDLE;
      end
      ST_WALK_RD: begin
        if ((i_r < cnt_a_r) && (j_r < cnt_b_r)) begin
          rd_en_a   = 1'b1;
          rd_en_b   = 1'b1;
          rd_addr_a = i_r[ADDR_W-1:0];
          rd_addr_b = j_r[ADDR_W-1:0];
          state_nxt = ST_WALK_CMP;
        end else begin
          res_nxt   = '{found: 1'b0, meet_start: '0, meet_end: '0, overflow: drop_r};
          state_nxt = ST_DONE;
        end
      end
      ST_WALK_CMP: begin
        if (hit_v) begin
          res_nxt   = '{found: 1'b1, meet_start: lo_v, meet_end: lo_v + min_dur,
                        overflow: drop_r};
          state_nxt = ST_DONE;
        end else begin
          if (ae_v <= be_v) i_nxt = i_r + CNT_W'(1);
          else              j_nxt = j_r + CNT_W'(1);
          state_nxt = ST_WALK_RD;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          cnt_a_nxt = '0;
          cnt_b_nxt = '0;
          drop_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      drop_r  <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      drop_r  <= drop_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    last_r <= last_nxt;
    key_r  <= key_nxt;
    pos_r  <= pos_nxt;
    res_r  <= res_nxt;
  end

endmodule

@@ hw/rtl/common_slot_finder.sv @@
// Common slot finder top: config register, result output register, engine.
// A slot goes straight into an empty store; otherwise each stored slot larger than
// it is moved up before the slot is written. A last word then starts the walk,
// whose result goes into the output register. Throughput: one word at a time.
// Reset (rst_n low, synchronous) clears counts, drop flag, state, output valid;
// min_duration resets to 1. Store contents are undefined until written.
`timescale 1ns / 1ps

module common_slot_finder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  csf_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output csf_pkg::out_word_t out_word,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);
  import csf_pkg::*;

  logic [31:0] min_dur_r;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r;
  logic        res_valid, res_ready;
  out_word_t   res_word;

  csf_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .min_dur(min_dur_r),
    .res_valid(res_valid), .res_ready(res_ready), .res_word(res_word)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) out_valid_nxt = 1'b1;
    else if (!out_stall)        out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dur_r   <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) min_dur_r <= cfg_wr_data;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_word_r <= res_word;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.found |-> out_word.meet_start == '0 && out_word.meet_end == '0)
    else $error("not found result carries nonzero times");

  a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_valid)
    else $error("accepted result not presented");

  a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.found |-> out_word.meet_end >= out_word.meet_start)
    else $error("meeting end wrapped");

endmodule
